/* src/rgb_to_hsv_converter_unit_macros.svh */
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication under reset
`define RTH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rgb_to_hsv: implication check failed");
// Next-cycle implication under reset
`define RTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rgb_to_hsv: next-cycle check failed");
`else
`define RTH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/rgb2hsv_pkg.sv */
// Types, constants and divider step functions for the RGB to HSV converter.
package rgb2hsv_pkg;

  localparam int ChanW    = 8;   // one color channel
  localparam int HueW     = 16;  // hue, 0.16 turn
  localparam int SatW     = 17;  // saturation, 1.16
  localparam int HueDivW  = 11;  // 6 * delta, up to 1530
  localparam int InDataW  = 24;  // red, green, blue
  localparam int OutDataW = 48;  // hue, saturation, value, zero pad
  localparam int NumSteps = 16;  // quotient bits resolved in the step stages
  localparam int NumStg   = NumSteps + 3;  // input, min/max, setup, steps

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Pixel as carried on tdata, red in the low byte
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0]        mx;
    logic [ChanW-1:0]        mn;
    sector_e                 sector;
    logic signed [ChanW:0]   diff;
  } ext_t;

  typedef struct packed {
    logic [HueDivW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [HueW-1:0]    hue_q;
    logic [ChanW-1:0]   sat_rem;
    logic [ChanW-1:0]   sat_div;
    logic [SatW-1:0]    sat_q;
    logic [ChanW-1:0]   value;
  } div_t;

  // One restoring step for the hue divider: {quotient bit, new remainder}
  function automatic logic [HueDivW:0] hue_step(logic [HueDivW-1:0] rem,
                                                logic [HueDivW-1:0] dv);
    logic [HueDivW:0] r2;
    logic [HueDivW:0] sub;
    logic             ge;
    r2  = {rem, 1'b0};
    sub = r2 - {1'b0, dv};
    ge  = (r2 >= {1'b0, dv});
    return {ge, (ge ? sub[HueDivW-1:0] : r2[HueDivW-1:0])};
  endfunction

  // One restoring step for the saturation divider
  function automatic logic [ChanW:0] sat_step(logic [ChanW-1:0] rem,
                                              logic [ChanW-1:0] dv);
    logic [ChanW:0] r2;
    logic [ChanW:0] sub;
    logic           ge;
    r2  = {rem, 1'b0};
    sub = r2 - {1'b0, dv};
    ge  = (r2 >= {1'b0, dv});
    return {ge, (ge ? sub[ChanW-1:0] : r2[ChanW-1:0])};
  endfunction

endpackage

/* src/rgb_to_hsv_converter_unit.sv */
// RGB to HSV converter: 8-bit RGB pixel in, fixed-point hue/saturation/value out.
// Takes one pixel per clock while the output side does not stall and returns one
// result per pixel, in order. The two restoring dividers (hue and saturation)
// resolve one quotient bit per pipeline stage over 16 stages, behind an input
// register, a min/max stage and a setup stage. Each stage holds only while the
// stage after it is full and stalled, so bubbles close up and input is taken
// while a result waits at the output.
// Hue is floor(65536 * fraction of a turn), wrapped to 0..65535; gray gives 0.
// Saturation is floor(65536 * (max - min) / max), 0 for black. Value is the max.
`include "rgb_to_hsv_converter_unit_macros.svh"

module rgb_to_hsv_converter_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [rgb2hsv_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] hue, [32:16] saturation, [40:33] value, [47:41] zero
  output logic [rgb2hsv_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rgb2hsv_pkg::*;

  // Per-stage valid and load enable
  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] en;

  pix_t pix_q;
  ext_t ext_d, ext_q;
  div_t div_d;
  div_t div_q [NumSteps+1];

  // Stage loads when empty or when its successor moves
  assign en[NumStg-1] = !v_q[NumStg-1] || m_axis_tready_i;
  for (genvar i = 0; i < NumStg - 1; i++) begin : g_en
    assign en[i] = !v_q[i] || en[i+1];
  end

  assign s_axis_tready_o = en[0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pix_q <= pix_t'(s_axis_tdata_i);
    end
  end

  // Max, min and dominant sector; ties go red, then green
  always_comb begin
    ext_d = '0;
    if (pix_q.red >= pix_q.green && pix_q.red >= pix_q.blue) begin
      ext_d.sector = SEC_RED;
      ext_d.mx     = pix_q.red;
      ext_d.diff   = $signed({1'b0, pix_q.green}) - $signed({1'b0, pix_q.blue});
    end else if (pix_q.green >= pix_q.blue) begin
      ext_d.sector = SEC_GREEN;
      ext_d.mx     = pix_q.green;
      ext_d.diff   = $signed({1'b0, pix_q.blue}) - $signed({1'b0, pix_q.red});
    end else begin
      ext_d.sector = SEC_BLUE;
      ext_d.mx     = pix_q.blue;
      ext_d.diff   = $signed({1'b0, pix_q.red}) - $signed({1'b0, pix_q.green});
    end
    ext_d.mn = pix_q.red;
    if (pix_q.green < ext_d.mn) ext_d.mn = pix_q.green;
    if (pix_q.blue < ext_d.mn) ext_d.mn = pix_q.blue;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ext_q <= ext_d;
    end
  end

  // Divider setup: hue numerator wrapped into [0, 6*delta), first saturation bit
  logic [ChanW-1:0]     delta;
  logic [ChanW+1:0]     kd;
  logic [HueDivW-1:0]   six_d;
  logic signed [HueDivW:0] t_pos;
  logic signed [HueDivW:0] t_wrap;
  logic                 sat_full;

  always_comb begin
    delta = ext_q.mx - ext_q.mn;
    case (ext_q.sector)
      SEC_RED:   kd = '0;
      SEC_GREEN: kd = {1'b0, delta, 1'b0};
      SEC_BLUE:  kd = {delta, 2'b00};
      default:   kd = '0;
    endcase
    six_d  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    t_pos  = $signed({2'b00, kd}) + {{(HueDivW-ChanW){ext_q.diff[ChanW]}}, ext_q.diff};
    t_wrap = t_pos[HueDivW] ? (t_pos + $signed({1'b0, six_d})) : t_pos;
    sat_full = (ext_q.mn == '0) && (ext_q.mx != '0);

    div_d.hue_rem = t_wrap[HueDivW-1:0];
    // A gray pixel divides zero by one, giving hue 0
    div_d.hue_div = (delta == '0) ? HueDivW'(1) : six_d;
    div_d.hue_q   = '0;
    div_d.sat_rem = sat_full ? '0 : delta;
    // Black divides zero by one, giving saturation 0
    div_d.sat_div = (ext_q.mx == '0) ? ChanW'(1) : ext_q.mx;
    div_d.sat_q   = {{(SatW-1){1'b0}}, sat_full};
    div_d.value   = ext_q.mx;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      div_q[0] <= div_d;
    end
  end

  // Restoring division, one quotient bit of each divider per stage
  for (genvar s = 1; s <= NumSteps; s++) begin : g_step
    logic [HueDivW:0] hs;
    logic [ChanW:0]   ss;
    div_t             nxt;

    always_comb begin
      hs            = hue_step(div_q[s-1].hue_rem, div_q[s-1].hue_div);
      ss            = sat_step(div_q[s-1].sat_rem, div_q[s-1].sat_div);
      nxt           = div_q[s-1];
      nxt.hue_rem   = hs[HueDivW-1:0];
      nxt.hue_q     = {div_q[s-1].hue_q[HueW-2:0], hs[HueDivW]};
      nxt.sat_rem   = ss[ChanW-1:0];
      nxt.sat_q     = {div_q[s-1].sat_q[SatW-2:0], ss[ChanW]};
    end

    always_ff @(posedge clk_i) begin
      if (en[s+2]) begin
        div_q[s] <= nxt;
      end
    end
  end

  // Output transfer
  assign m_axis_tvalid_o = v_q[NumStg-1];
  assign m_axis_tdata_o  = {{(OutDataW-HueW-SatW-ChanW){1'b0}},
                            div_q[NumSteps].value,
                            div_q[NumSteps].sat_q,
                            div_q[NumSteps].hue_q};

  // Black result must carry zero hue and zero saturation
  `RTH_ASSERT_IMPLY(a_black_zero, clk_i, rst_ni,
    m_axis_tvalid_o && div_q[NumSteps].value == '0,
    div_q[NumSteps].hue_q == '0 && div_q[NumSteps].sat_q == '0)
  // Saturation never exceeds one full unit
  `RTH_ASSERT_IMPLY(a_sat_range, clk_i, rst_ni,
    m_axis_tvalid_o && div_q[NumSteps].sat_q[SatW-1],
    div_q[NumSteps].sat_q[SatW-2:0] == '0)
  // Division remainders stay below their divisors
  `RTH_ASSERT_IMPLY(a_rem_bound, clk_i, rst_ni,
    v_q[NumStg-1],
    div_q[NumSteps].hue_rem < div_q[NumSteps].hue_div &&
    div_q[NumSteps].sat_rem < div_q[NumSteps].sat_div)
  // Input backpressure only comes from a stalled output
  `RTH_ASSERT_IMPLY(a_ready_cause, clk_i, rst_ni,
    !s_axis_tready_o,
    m_axis_tvalid_o && !m_axis_tready_i)

endmodule
